// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OLFE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("olfe assertion failed");
`define OLFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olfe assertion failed");
`else
`define OLFE_ASSERT(lbl, clk, rst_n, prop)
`define OLFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/olfe_pkg.sv -----
`timescale 1ns / 1ps
package olfe_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int N_W      = 12;
    localparam int S_W      = 28;
    localparam int SQ_W     = 42;
    localparam int XY_W     = 43;
    localparam int ERR_W    = 60;
    localparam int NSQ_W    = 24;
    localparam int P_W      = 56;
    localparam int C_W      = 57;
    localparam int M_W      = 56;
    localparam int H_W      = 28;
    localparam int D_W      = 116;
    localparam int R_W      = 58;
    localparam int RM_W     = 60;
    localparam int E_W      = 59;
    localparam int NUM_W    = 56;
    localparam int Q_W      = 72;
    localparam int NEAR_W   = 42;
    localparam int SMALL_W  = 25;
    localparam int NEAR_XY  = 100000;
    localparam int NEAR_E   = 50000;

    typedef struct packed {
        logic [N_W-1:0]          n;
        logic [NSQ_W-1:0]        nsq;
        logic signed [C_W-1:0]   cxx;
        logic signed [C_W-1:0]   cyy;
        logic signed [C_W-1:0]   dxy;
        logic [C_W-1:0]          cxy_mag;
    } t_fit_side;

    typedef struct packed {
        logic [N_W-1:0] n;
        logic           vert;
        logic           zero;
    } t_div_side;
endpackage

// ----- rtl/olfe_moments.sv -----
`timescale 1ns / 1ps
module olfe_moments
    import olfe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [N_W-1:0]          i_point_count,
    input  logic signed [S_W-1:0]   i_sum_x,
    input  logic signed [S_W-1:0]   i_sum_y,
    input  logic [SQ_W-1:0]         i_sum_xx,
    input  logic [SQ_W-1:0]         i_sum_yy,
    input  logic signed [XY_W-1:0]  i_sum_xy,
    output logic                    o_valid,
    output logic [D_W-1:0]          o_d,
    output t_fit_side               o_side
);
    logic [5:0] r_v;

    logic [N_W-1:0]          n_c;
    logic [N_W-1:0]          r1_n;
    logic [NSQ_W-1:0]        r1_nsq;
    logic [SQ_W+N_W-1:0]     r1_nxx, r1_nyy;
    logic signed [P_W-1:0]   r1_nxy, r1_xx, r1_yy, r1_xy;

    logic [N_W-1:0]          r2_n;
    logic [NSQ_W-1:0]        r2_nsq;
    logic signed [C_W-1:0]   r2_cxx, r2_cyy, r2_cxy;

    logic signed [C_W-1:0]   dxy_c;
    logic [C_W-1:0]          cxy_mag_c;
    logic [M_W-1:0]          r3_a, r3_b;
    t_fit_side               r3_side, r4_side, r5_side, r6_side;

    logic [2*H_W-1:0]        r4_ahh, r4_ahl, r4_all, r4_bhh, r4_bhl, r4_bll;
    logic [D_W-1:0]          r5_sa, r5_sb, r6_d;

    always_comb begin
        n_c = i_point_count;
        if (32'(i_point_count) >= MAX_POINTS) begin
            n_c = N_W'(MAX_POINTS - 1);
        end
        dxy_c     = r2_cxx - r2_cyy;
        cxy_mag_c = r2_cxy[C_W-1] ? C_W'(-r2_cxy) : C_W'(r2_cxy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_n   <= n_c;
            r1_nsq <= NSQ_W'(n_c * n_c);
            r1_nxx <= (SQ_W+N_W)'(n_c) * (SQ_W+N_W)'(i_sum_xx);
            r1_nyy <= (SQ_W+N_W)'(n_c) * (SQ_W+N_W)'(i_sum_yy);
            r1_nxy <= P_W'($signed({1'b0, n_c})) * P_W'(i_sum_xy);
            r1_xx  <= P_W'(i_sum_x) * P_W'(i_sum_x);
            r1_yy  <= P_W'(i_sum_y) * P_W'(i_sum_y);
            r1_xy  <= P_W'(i_sum_x) * P_W'(i_sum_y);

            r2_n   <= r1_n;
            r2_nsq <= r1_nsq;
            r2_cxx <= C_W'($signed({1'b0, r1_nxx})) - C_W'(r1_xx);
            r2_cyy <= C_W'($signed({1'b0, r1_nyy})) - C_W'(r1_yy);
            r2_cxy <= C_W'(r1_nxy) - C_W'(r1_xy);

            r3_side.n       <= r2_n;
            r3_side.nsq     <= r2_nsq;
            r3_side.cxx     <= r2_cxx;
            r3_side.cyy     <= r2_cyy;
            r3_side.dxy     <= dxy_c;
            r3_side.cxy_mag <= cxy_mag_c;
            r3_a <= dxy_c[C_W-1] ? M_W'(-dxy_c) : M_W'(dxy_c);
            r3_b <= {cxy_mag_c[M_W-2:0], 1'b0};

            r4_side <= r3_side;
            r4_ahh  <= r3_a[M_W-1:H_W] * r3_a[M_W-1:H_W];
            r4_ahl  <= r3_a[M_W-1:H_W] * r3_a[H_W-1:0];
            r4_all  <= r3_a[H_W-1:0] * r3_a[H_W-1:0];
            r4_bhh  <= r3_b[M_W-1:H_W] * r3_b[M_W-1:H_W];
            r4_bhl  <= r3_b[M_W-1:H_W] * r3_b[H_W-1:0];
            r4_bll  <= r3_b[H_W-1:0] * r3_b[H_W-1:0];

            r5_side <= r4_side;
            r5_sa <= (D_W'(r4_ahh) << (2*H_W)) + (D_W'(r4_ahl) << (H_W+1)) + D_W'(r4_all);
            r5_sb <= (D_W'(r4_bhh) << (2*H_W)) + (D_W'(r4_bhl) << (H_W+1)) + D_W'(r4_bll);

            r6_side <= r5_side;
            r6_d    <= r5_sa + r5_sb;
        end
    end

    assign o_valid = r_v[5];
    assign o_d     = r6_d;
    assign o_side  = r6_side;
endmodule

// ----- rtl/olfe_sqrt.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module olfe_sqrt
    import olfe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [D_W-1:0]  i_d,
    input  t_fit_side       i_side,
    output logic            o_valid,
    output logic [R_W-1:0]  o_root,
    output t_fit_side       o_side
);
    // one root bit per stage, restoring digit recurrence
    logic                   r_v    [R_W];
    logic [D_W-1:0]         r_d    [R_W];
    logic [RM_W-1:0]        r_rem  [R_W];
    logic [R_W-1:0]         r_root [R_W];
    t_fit_side              r_side [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic            v_in;
        logic [D_W-1:0]  d_in;
        logic [RM_W-1:0] rem_in, rem_s, trial;
        logic [R_W-1:0]  root_in;
        t_fit_side       side_in;
        logic            ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign d_in    = i_d;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign d_in    = r_d[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        assign rem_s = {rem_in[RM_W-3:0], d_in[D_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (rem_s >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[k]    <= d_in << 2;
                r_rem[k]  <= ge ? rem_s - trial : rem_s;
                r_root[k] <= {root_in[R_W-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[R_W-1];
    assign o_root  = r_root[R_W-1];
    assign o_side  = r_side[R_W-1];

    `OLFE_ASSERT(a_sqrt_rem, i_clk, i_rst_n, o_valid |-> (r_rem[R_W-1] <= {1'b0, o_root, 1'b0}))
endmodule

// ----- rtl/olfe_div.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module olfe_div
    import olfe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [Q_W-1:0]  i_dividend,
    input  t_div_side       i_side,
    output logic            o_valid,
    output logic [Q_W-1:0]  o_quot,
    output t_div_side       o_side
);
    // one quotient bit per stage; quotient bits shift in as dividend bits shift out
    logic               r_v    [Q_W];
    logic [Q_W-1:0]     r_dvd  [Q_W];
    logic [N_W-1:0]     r_rem  [Q_W];
    t_div_side          r_side [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic           v_in;
        logic [Q_W-1:0] dvd_in;
        logic [N_W-1:0] rem_in;
        t_div_side      side_in;
        logic [N_W:0]   t;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign dvd_in  = i_dividend;
            assign rem_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign dvd_in  = r_dvd[k-1];
            assign rem_in  = r_rem[k-1];
            assign side_in = r_side[k-1];
        end

        assign t  = {rem_in, dvd_in[Q_W-1]};
        assign ge = (t >= {1'b0, side_in.n});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvd[k]  <= {dvd_in[Q_W-2:0], ge};
                r_rem[k]  <= ge ? N_W'(t - {1'b0, side_in.n}) : t[N_W-1:0];
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_dvd[Q_W-1];
    assign o_side  = r_side[Q_W-1];

    `OLFE_ASSERT(a_div_rem, i_clk, i_rst_n, (o_valid && (o_side.n != '0)) |-> (r_rem[Q_W-1] < o_side.n))
endmodule

// ----- rtl/orthogonal_line_fit_error_core.sv -----
`timescale 1ns / 1ps
// Orthogonal line fit residual, fully pipelined.
// Input channel: i_valid / o_stall with the point count and the five
// running sums of one segment; a request is taken on a rising edge with
// i_valid high and o_stall low. Output channel: o_valid / i_stall with the
// squared perpendicular distance sum (unsigned Q44.16, clamped at all ones),
// the vertical-line flag and the clamp flag.
// Throughput: one request per cycle while o_stall is low. Stages from
// acceptance to o_valid: 6 moment and square stages, 58 square-root stages
// (one root bit each), 2 branch stages, 72 divider stages (one quotient bit
// each) and the output register.
// Stall: while a result sits in the output register and i_stall is high, the
// whole pipeline holds and o_stall is raised; nothing is dropped or repeated.
// Reset (synchronous, active low) clears every valid bit; the block takes
// requests in the first cycle after reset is released.
`include "assert_macros.svh"
module orthogonal_line_fit_error_core
    import olfe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [N_W-1:0]          i_point_count,
    input  logic signed [S_W-1:0]   i_sum_x,
    input  logic signed [S_W-1:0]   i_sum_y,
    input  logic [SQ_W-1:0]         i_sum_xx,
    input  logic [SQ_W-1:0]         i_sum_yy,
    input  logic signed [XY_W-1:0]  i_sum_xy,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ERR_W-1:0]        o_error_sum,
    output logic                    o_vertical_fit,
    output logic                    o_saturated
);
    logic            en;
    logic            mom_valid, sq_valid, div_valid;
    logic [D_W-1:0]  mom_d;
    t_fit_side       mom_side, sq_side;
    logic [R_W-1:0]  sq_root;
    logic [Q_W-1:0]  div_quot;
    t_div_side       div_side;

    logic                    r_b1_valid, r_b2_valid;
    logic [N_W-1:0]          r_b1_n;
    logic [NSQ_W-1:0]        r_b1_nsq;
    logic signed [C_W-1:0]   r_b1_cxx, r_b1_cyy;
    logic signed [E_W-1:0]   r_b1_e, r_b1_s3;
    logic                    r_b1_near;
    logic                    xy_near_c;

    logic [E_W-1:0]          e_mag;
    logic                    vert_c;
    logic signed [E_W-1:0]   num_c;
    logic                    nonpos_c;
    logic [Q_W-1:0]          r_b2_dvd;
    t_div_side               r_b2_side;

    logic                    r_out_valid;
    logic [ERR_W-1:0]        r_err;
    logic                    r_vert, r_sat;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    olfe_moments u_moments (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_valid),
        .i_point_count (i_point_count),
        .i_sum_x       (i_sum_x),
        .i_sum_y       (i_sum_y),
        .i_sum_xx      (i_sum_xx),
        .i_sum_yy      (i_sum_yy),
        .i_sum_xy      (i_sum_xy),
        .o_valid       (mom_valid),
        .o_d           (mom_d),
        .o_side        (mom_side)
    );

    olfe_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mom_valid),
        .i_d     (mom_d),
        .i_side  (mom_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign xy_near_c = (sq_side.cxy_mag[C_W-1:SMALL_W] == '0) &&
        ((NEAR_W'(sq_side.cxy_mag[SMALL_W-1:0]) * NEAR_W'(NEAR_XY)) < NEAR_W'(sq_side.nsq));

    always_comb begin
        e_mag  = r_b1_e[E_W-1] ? E_W'(-r_b1_e) : E_W'(r_b1_e);
        vert_c = r_b1_near && (e_mag[E_W-1:SMALL_W] == '0) &&
            ((NEAR_W'(e_mag[SMALL_W-1:0]) * NEAR_W'(NEAR_E)) < NEAR_W'(r_b1_nsq));
        if (vert_c) begin
            num_c = E_W'(r_b1_cxx);
        end else if (r_b1_near) begin
            num_c = E_W'(r_b1_cyy);
        end else begin
            num_c = r_b1_s3;
        end
        nonpos_c = num_c[E_W-1] || (num_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_b1_valid  <= sq_valid;
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_n    <= sq_side.n;
            r_b1_nsq  <= sq_side.nsq;
            r_b1_cxx  <= sq_side.cxx;
            r_b1_cyy  <= sq_side.cyy;
            r_b1_near <= xy_near_c;
            r_b1_e    <= E_W'(sq_side.dxy) + $signed({1'b0, sq_root});
            r_b1_s3   <= E_W'(sq_side.cxx) + E_W'(sq_side.cyy) - $signed({1'b0, sq_root});

            r_b2_dvd  <= r_b1_near ? {num_c[NUM_W-1:0], 16'b0}
                                   : {1'b0, num_c[NUM_W-1:0], 15'b0};
            r_b2_side.n    <= r_b1_n;
            r_b2_side.vert <= vert_c && (r_b1_n != '0);
            r_b2_side.zero <= nonpos_c || (r_b1_n == '0);

            r_vert <= div_side.vert;
            if (div_side.zero) begin
                r_err <= '0;
                r_sat <= 1'b0;
            end else if (div_quot[Q_W-1:ERR_W] != '0) begin
                r_err <= '1;
                r_sat <= 1'b1;
            end else begin
                r_err <= div_quot[ERR_W-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    olfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_b2_valid),
        .i_dividend (r_b2_dvd),
        .i_side     (r_b2_side),
        .o_valid    (div_valid),
        .o_quot     (div_quot),
        .o_side     (div_side)
    );

    assign o_valid        = r_out_valid;
    assign o_error_sum    = r_err;
    assign o_vertical_fit = r_vert;
    assign o_saturated    = r_sat;

    `OLFE_ASSERT(a_sat_max, i_clk, i_rst_n, (o_valid && o_saturated) |-> (o_error_sum == '1))
    `OLFE_ASSERT(a_stall_held, i_clk, i_rst_n, o_stall |-> o_valid)
    `OLFE_ASSERT_NEXT(a_div_capture, i_clk, i_rst_n, div_valid && en, o_valid)
endmodule
